@@ hw/rtl/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int WORD_WIDTH  = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [ADDR_W-1:0]            addr_t;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] op;
		word_t      value;
	} req_item_t;

	typedef struct packed {
		word_t      top_value;
		word_t      min_value;
		logic       has_data;
		logic [1:0] status;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
	} mts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_go;
		logic out_free;
	} mts_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/mts_if.sv @@
`default_nettype none

interface mts_req_if import mts_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/min_tracking_stack.sv @@
`default_nettype none

// channel  dir  payload                                      transfer
// req      in   op, value                                    valid & ready
// rsp      out  top_value, min_value, has_data, status       valid & ready
//
// push, query and rejected ops load the result register directly; a pop that
// removes a word loads it from the registered read of the value and minimum stores.
// tops of both stacks are cached in registers, the stores hold every word.
// reset clears the counts and the result valid flag; stores are not cleared.
// a result waiting on rsp blocks the next request unless it is drained in
// that same cycle, so a new one is only taken when the result register frees.

module min_tracking_stack import mts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	mts_cmd_t cmd;
	mts_sts_t sts;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mts_ctrl.sv @@
`default_nettype none

module mts_ctrl import mts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire mts_sts_t sts,
	output mts_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOAD = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign req_ready  = (state_q == S_IDLE) && sts.out_free;
	assign cmd.accept = req_valid && req_ready;
	assign cmd.load   = (state_q == S_LOAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				// a pop with data moves to S_LOAD to wait for the store read
				if (cmd.accept && sts.pop_go) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mts_dp.sv @@
`default_nettype none

module mts_dp import mts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mts_cmd_t  cmd,
	output mts_sts_t       sts,
	input  wire req_item_t req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp_data
);

	word_t     vmem [STACK_DEPTH];
	word_t     mmem [STACK_DEPTH];
	word_t     vrd_q, mrd_q;
	word_t     top_q, mintop_q;
	cnt_t      vcnt_q, mcnt_q;
	logic      out_valid_q;
	rsp_item_t out_q;

	cnt_t      vcnt_d, mcnt_d;
	word_t     top_d, mintop_d;
	status_t   stat;
	logic      full, empty, push_ok, push_min, pop_min;
	cnt_t      vaddr_full, maddr_full;
	rsp_item_t out_direct, out_loaded;

	assign full     = (vcnt_q == CNT_W'(STACK_DEPTH));
	assign empty    = (vcnt_q == '0);
	assign push_ok  = (req_data.op == OP_PUSH) && !full;
	assign push_min = ((mcnt_q == '0) || (req_data.value <= mintop_q))
		&& (mcnt_q < CNT_W'(STACK_DEPTH));
	assign pop_min  = (mcnt_q != '0) && (top_q == mintop_q);

	assign sts.pop_go   = (req_data.op == OP_POP) && !empty;
	assign sts.out_free = !out_valid_q || rsp_ready;

	always_comb begin
		vcnt_d   = vcnt_q;
		mcnt_d   = mcnt_q;
		top_d    = top_q;
		mintop_d = mintop_q;
		stat     = ST_OK;
		case (req_data.op)
			OP_PUSH: begin
				if (full) begin
					stat = ST_PUSH_FULL;
				end else begin
					vcnt_d = vcnt_q + CNT_W'(1);
					top_d  = req_data.value;
					if (push_min) begin
						mcnt_d   = mcnt_q + CNT_W'(1);
						mintop_d = req_data.value;
					end
				end
			end
			OP_POP: begin
				if (empty) begin
					stat = ST_POP_EMPTY;
				end else begin
					vcnt_d = vcnt_q - CNT_W'(1);
					if (pop_min) begin
						mcnt_d = mcnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// new tops after a pop sit one below the new counts
	assign vaddr_full = vcnt_q - CNT_W'(2);
	assign maddr_full = pop_min ? (mcnt_q - CNT_W'(2)) : (mcnt_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.accept && push_ok) begin
			vmem[vcnt_q[ADDR_W-1:0]] <= req_data.value;
		end
		if (cmd.accept && sts.pop_go) begin
			vrd_q <= vmem[vaddr_full[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && push_ok && push_min) begin
			mmem[mcnt_q[ADDR_W-1:0]] <= req_data.value;
		end
		if (cmd.accept && sts.pop_go) begin
			mrd_q <= mmem[maddr_full[ADDR_W-1:0]];
		end
	end

	always_comb begin
		out_direct.has_data  = (vcnt_d != '0);
		out_direct.top_value = out_direct.has_data ? top_d : '0;
		out_direct.min_value = (out_direct.has_data && (mcnt_d != '0)) ? mintop_d : '0;
		out_direct.status    = stat;

		out_loaded.has_data  = (vcnt_q != '0);
		out_loaded.top_value = out_loaded.has_data ? vrd_q : '0;
		out_loaded.min_value = (out_loaded.has_data && (mcnt_q != '0)) ? mrd_q : '0;
		out_loaded.status    = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				vcnt_q <= vcnt_d;
				mcnt_q <= mcnt_d;
			end
			if ((cmd.accept && !sts.pop_go) || cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			top_q    <= top_d;
			mintop_q <= mintop_d;
		end else if (cmd.load) begin
			top_q    <= vrd_q;
			mintop_q <= mrd_q;
		end
		if (cmd.accept && !sts.pop_go) begin
			out_q <= out_direct;
		end else if (cmd.load) begin
			out_q <= out_loaded;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/mts_checker.sv @@
`default_nettype none

module mts_checker import mts_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_item_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.has_data |->
			rsp_data.top_value == '0 && rsp_data.min_value == '0
			&& rsp_data.status != ST_PUSH_FULL)
		else $error("empty stack reports data");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_POP_EMPTY |-> !rsp_data.has_data)
		else $error("pop on empty with data");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.has_data |-> rsp_data.min_value <= rsp_data.top_value)
		else $error("minimum above top");

endmodule

bind min_tracking_stack mts_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

@@ tb/sv/min_tracking_stack_tb.sv @@
`timescale 1ns / 1ps

module min_tracking_stack_tb;
	import mts_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         PHASE_ITEMS = 232;
	localparam int         STALL_LIMIT = 4000;
	localparam int         DRAIN_WAIT  = 20;

	logic clk;
	logic arst_n;

	mts_req_if req_ch ();
	mts_rsp_if rsp_ch ();

	min_tracking_stack u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the two stacks
	word_t     stack_words [STACK_DEPTH];
	word_t     min_words [STACK_DEPTH];
	int        word_count;
	int        min_count;

	req_item_t pending_ops[$];
	rsp_item_t expected_results[$];
	rsp_item_t want_rsp;

	int        sender_idle_pct;
	int        receiver_stall_pct;
	int        mismatch_count;
	int        requests_done;
	int        results_done;
	int        full_pushes;
	int        empty_pops;
	int        min_stack_peak;
	int        quiet_cycles;

	always #5 clk = ~clk;

	function automatic rsp_item_t apply_stack_op(req_item_t item);
		rsp_item_t res;
		res = '0;
		res.status = ST_OK;
		case (item.op)
			OP_PUSH: begin
				if (word_count >= STACK_DEPTH) begin
					res.status = ST_PUSH_FULL;
					full_pushes++;
				end else begin
					stack_words[word_count] = item.value;
					word_count++;
					// signed compare, equal words stack up too
					if (min_count == 0 || item.value <= min_words[min_count-1]) begin
						if (min_count < STACK_DEPTH) begin
							min_words[min_count] = item.value;
							min_count++;
						end
					end
				end
			end
			OP_POP: begin
				if (word_count == 0) begin
					res.status = ST_POP_EMPTY;
					empty_pops++;
				end else begin
					if (min_count > 0 && stack_words[word_count-1] == min_words[min_count-1])
						min_count--;
					word_count--;
				end
			end
			default: ;
		endcase
		if (min_count > min_stack_peak)
			min_stack_peak = min_count;
		if (word_count > 0) begin
			res.top_value = stack_words[word_count-1];
			res.min_value = (min_count > 0) ? min_words[min_count-1] : word_t'(0);
			res.has_data  = 1'b1;
		end
		return res;
	endfunction

	function automatic word_t pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return word_t'(int'($urandom_range(0, 8)) - 4);
		if (sel == 4) begin
			case ($urandom_range(0, 3))
				0: return word_t'(32'h7fff_ffff);
				1: return word_t'(32'h8000_0000);
				2: return word_t'(0);
				default: return word_t'(-1);
			endcase
		end
		return word_t'($urandom);
	endfunction

	task automatic add_op(logic [1:0] op, word_t value);
		req_item_t item;
		item.op    = op;
		item.value = value;
		pending_ops.insert(pending_ops.size(), item);
	endtask

	// driver: next request goes out once the current one transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.insert(expected_results.size(),
					apply_stack_op(req_ch.data));
				requests_done++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pending_ops.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_done++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: top %0d min %0d",
						rsp_ch.data.top_value, rsp_ch.data.min_value);
					mismatch_count++;
				end else begin
					want_rsp = expected_results.pop_front();
					if (rsp_ch.data.top_value !== want_rsp.top_value) begin
						$error("top_value: expected %0d, got %0d",
							want_rsp.top_value, rsp_ch.data.top_value);
						mismatch_count++;
					end
					if (rsp_ch.data.min_value !== want_rsp.min_value) begin
						$error("min_value: expected %0d, got %0d",
							want_rsp.min_value, rsp_ch.data.min_value);
						mismatch_count++;
					end
					if (rsp_ch.data.has_data !== want_rsp.has_data) begin
						$error("has_data: expected %0d, got %0d",
							want_rsp.has_data, rsp_ch.data.has_data);
						mismatch_count++;
					end
					if (rsp_ch.data.status !== want_rsp.status) begin
						$error("status: expected %0d, got %0d",
							want_rsp.status, rsp_ch.data.status);
						mismatch_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int    phase_idx;
		int    phase_start;
		int    run_len;
		int    sel;
		word_t fill_word;

		clk                = 1'b0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.data        = '0;
		rsp_ch.ready       = 1'b0;
		word_count         = 0;
		min_count          = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		mismatch_count     = 0;
		requests_done      = 0;
		results_done       = 0;
		full_pushes        = 0;
		empty_pops         = 0;
		min_stack_peak     = 0;
		quiet_cycles       = 0;

		// directed: empty-stack cases, extremes, duplicate minimum
		add_op(OP_QUERY, '0);
		add_op(OP_POP, word_t'(32'h1234_5678));
		add_op(OP_UNUSED, '0);
		add_op(OP_PUSH, word_t'(32'h7fff_ffff));
		add_op(OP_PUSH, word_t'(32'h8000_0000));
		add_op(OP_PUSH, word_t'(-1));
		add_op(OP_PUSH, word_t'(0));
		add_op(OP_PUSH, word_t'(32'h8000_0000));
		add_op(OP_QUERY, word_t'(-1));
		add_op(OP_UNUSED, word_t'(-1));
		repeat (5) add_op(OP_POP, '0);
		add_op(OP_POP, '0);
		add_op(OP_PUSH, word_t'(5));
		add_op(OP_PUSH, word_t'(5));
		add_op(OP_PUSH, word_t'(6));
		add_op(OP_POP, '0);
		add_op(OP_POP, '0);
		add_op(OP_QUERY, '0);
		add_op(OP_POP, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
				default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
			endcase
			phase_start = pending_ops.size();

			// mixed runs with a fill-to-full burst in the middle
			while (pending_ops.size() - phase_start < PHASE_ITEMS) begin
				if (pending_ops.size() - phase_start >= PHASE_ITEMS / 3 &&
					pending_ops.size() - phase_start < PHASE_ITEMS / 3 + 16) begin
					// in even phases the pushed words are non-increasing, so the minimum stack can fill as well
					fill_word = word_t'(32'h7fff_fff0 - $urandom_range(0, 64));
					repeat (STACK_DEPTH + 4) begin
						if (phase_idx % 2 == 0) begin
							add_op(OP_PUSH, fill_word);
							fill_word = fill_word - word_t'($urandom_range(0, 3));
						end else begin
							add_op(OP_PUSH, pick_word());
						end
					end
					repeat (STACK_DEPTH + 6) add_op(OP_POP, pick_word());
				end
				run_len = $urandom_range(8, 16);
				repeat (run_len) begin
					sel = $urandom_range(0, 99);
					if (sel < 48)
						add_op(OP_PUSH, pick_word());
					else if (sel < 83)
						add_op(OP_POP, pick_word());
					else if (sel < 95)
						add_op(OP_QUERY, pick_word());
					else
						add_op(OP_UNUSED, pick_word());
				end
			end

			while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_WAIT) @(negedge clk);

		$display("covered %0d operations and %0d results over four back-pressure phases",
			requests_done, results_done);
		$display("%0d pushes on a full stack, %0d pops on an empty one, min stack peak %0d",
			full_pushes, empty_pops, min_stack_peak);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
